// ----- rtl/core/mreg_pkg.sv -----
// ----------------------------------------------------------------------------
// mreg_pkg: shared types and constants for the mouse report event generator
// Event kinds, per-slot state layout and sizing constants.
// ----------------------------------------------------------------------------
package mreg_pkg;

	localparam int NUM_SLOTS_DEF = 4;
	localparam int NUM_BUTTONS   = 3;
	localparam int MAX_EVENTS    = 4;
	localparam int MOTION_W      = 24;

	typedef enum logic [1:0] {
		KIND_PRESS   = 2'd0,
		KIND_HOLD    = 2'd1,
		KIND_RELEASE = 2'd2,
		KIND_MOTION  = 2'd3
	} kind_t;

	localparam logic [1:0] CODE_NONE = 2'd0;

	// Per-slot state word kept in the state memory
	typedef struct packed {
		logic [NUM_BUTTONS-1:0] buttons;
		logic [MOTION_W-1:0]    motion;
	} slot_state_t;

	typedef struct packed {
		kind_t      kind;
		logic [1:0] code;
	} event_t;

endpackage

// ----- rtl/core/mreg_state_mem.sv -----
// ----------------------------------------------------------------------------
// mreg_state_mem: per-slot state memory
// One write and one read port, registered read, valid bits for reset and
// forwarding of a write that lands on the edge of a read to the same slot.
// ----------------------------------------------------------------------------
module mreg_state_mem #(
	parameter int NUM_SLOTS = mreg_pkg::NUM_SLOTS_DEF,
	parameter int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  rd_en,
	input  logic [SLOT_W-1:0]     rd_addr,
	output mreg_pkg::slot_state_t rd_data,
	input  logic                  wr_en,
	input  logic [SLOT_W-1:0]     wr_addr,
	input  mreg_pkg::slot_state_t wr_data
);

	mreg_pkg::slot_state_t mem [NUM_SLOTS];
	logic [NUM_SLOTS-1:0]  valid_q;

	mreg_pkg::slot_state_t rd_raw_q;
	logic                  rd_vld_q;
	logic                  fwd_hit_q;
	mreg_pkg::slot_state_t fwd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_raw_q   <= mem[rd_addr];
			fwd_data_q <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			rd_vld_q  <= 1'b0;
			fwd_hit_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q  <= valid_q[rd_addr];
				fwd_hit_q <= wr_en && (wr_addr == rd_addr);
			end
		end
	end

	// An entry never written reads as its reset value of zero
	always_comb begin
		if (fwd_hit_q) begin
			rd_data = fwd_data_q;
		end else if (rd_vld_q) begin
			rd_data = rd_raw_q;
		end else begin
			rd_data = '0;
		end
	end

endmodule

// ----- rtl/core/mouse_report_event_generator.sv -----
// ----------------------------------------------------------------------------
// mouse_report_event_generator: boot-protocol mouse report to event items
// Turns each mouse report into press, hold, release and motion items,
// keeping the last buttons and motion of every slot in a state memory.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------
//  in      | input     | in_valid / in_ready    | device_slot, transfer_error,
//          |           |                        | button_byte, move_x/y/z
//  out     | output    | out_valid / out_ready  | event_kind, button_code,
//          |           |                        | out_x/y/z, last_event
//
//  A report is accepted into stage 1 while the state of its slot is read from
//  the state memory (registered read). Stage 1 builds the event list (0 to 4
//  items) and writes the new state back; stage 2 sends one item per cycle
//  while out_ready is high, bounded by the single output port. A report may
//  enter while the previous one still sends. Reset clears the valid bit of
//  every slot at once: no clearing pass. A stalled output holds stage 2,
//  then stage 1, then in_ready drops.
//
module mouse_report_event_generator #(
	parameter int NUM_SLOTS = mreg_pkg::NUM_SLOTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        device_slot,
	input  logic              transfer_error,
	input  logic [7:0]        button_byte,
	input  logic signed [7:0] move_x,
	input  logic signed [7:0] move_y,
	input  logic signed [7:0] move_z,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        event_kind,
	output logic [1:0]        button_code,
	output logic signed [7:0] out_x,
	output logic signed [7:0] out_y,
	output logic signed [7:0] out_z,
	output logic              last_event
);

	localparam int SLOT_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int NB      = mreg_pkg::NUM_BUTTONS;
	localparam int NE      = mreg_pkg::MAX_EVENTS;
	localparam int CNT_W   = $clog2(NE + 1);
	localparam int POS_W   = $clog2(NE);

	// Input decode: widen the slot so the range check works for any depth
	logic [15:0]       slot_ext;
	logic [SLOT_W-1:0] slot_idx;
	logic              in_acc;

	assign slot_ext = 16'(device_slot);
	assign slot_idx = slot_ext[SLOT_W-1:0];
	assign in_acc   = in_valid && in_ready;

	// Stage 1: report waiting for its event list
	logic                              valid_s1;
	logic                              act_s1;
	logic [SLOT_W-1:0]                 slot_s1;
	logic [NB-1:0]                     btn_s1;
	logic [mreg_pkg::MOTION_W-1:0]     motion_s1;

	// Stage 2: event list being sent
	logic                   valid_s2;
	mreg_pkg::event_t       ev_s2 [NE];
	logic [CNT_W-1:0]       cnt_s2;
	logic [POS_W-1:0]       pos_s2;
	logic [7:0]             mx_s2;
	logic [7:0]             my_s2;
	logic [7:0]             mz_s2;

	mreg_pkg::slot_state_t  rd_state;
	mreg_pkg::slot_state_t  wr_state;
	logic                   mem_we;

	mreg_pkg::event_t       ev_list [NE];
	logic [CNT_W-1:0]       ev_cnt;
	logic                   emitted;
	logic                   motion_ok;
	logic                   out_acc;
	logic                   out_done;
	logic                   s2_free;
	logic                   s1_adv;

	mreg_state_mem #(
		.NUM_SLOTS (NUM_SLOTS),
		.SLOT_W    (SLOT_W)
	) u_state_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (in_acc),
		.rd_addr (slot_idx),
		.rd_data (rd_state),
		.wr_en   (mem_we),
		.wr_addr (slot_s1),
		.wr_data (wr_state)
	);

	// Build the event list: first scan gives press, hold or a single motion
	// item; second scan gives releases. Pack the items in order.
	assign motion_ok = (motion_s1 != '0) && (motion_s1 != rd_state.motion);

	always_comb begin
		emitted = 1'b0;
		ev_cnt  = '0;
		for (int i = 0; i < NE; i++) begin
			ev_list[i] = '{kind: mreg_pkg::KIND_MOTION, code: mreg_pkg::CODE_NONE};
		end
		for (int b = 0; b < NB; b++) begin
			if (btn_s1[b]) begin
				ev_list[ev_cnt[POS_W-1:0]].kind = rd_state.buttons[b] ?
					mreg_pkg::KIND_HOLD : mreg_pkg::KIND_PRESS;
				ev_list[ev_cnt[POS_W-1:0]].code = 2'(b + 1);
				ev_cnt  = ev_cnt + 1'b1;
				emitted = 1'b1;
			end else if (motion_ok && !emitted) begin
				ev_list[ev_cnt[POS_W-1:0]].kind = mreg_pkg::KIND_MOTION;
				ev_list[ev_cnt[POS_W-1:0]].code = mreg_pkg::CODE_NONE;
				ev_cnt  = ev_cnt + 1'b1;
				emitted = 1'b1;
			end
		end
		for (int b = 0; b < NB; b++) begin
			if (!btn_s1[b] && rd_state.buttons[b]) begin
				ev_list[ev_cnt[POS_W-1:0]].kind = mreg_pkg::KIND_RELEASE;
				ev_list[ev_cnt[POS_W-1:0]].code = 2'(b + 1);
				ev_cnt = ev_cnt + 1'b1;
			end
		end
	end

	// Handshake: stage 1 moves on when its items fit into stage 2;
	// dropped reports and reports with no items need no room there.
	assign out_acc  = out_valid && out_ready;
	assign out_done = out_acc && last_event;
	assign s2_free  = !valid_s2 || out_done;
	assign s1_adv   = valid_s1 && (!act_s1 || (ev_cnt == '0) || s2_free);
	assign in_ready = !valid_s1 || s1_adv;

	// Write back the new state of an accepted report
	assign mem_we           = s1_adv && act_s1;
	assign wr_state.buttons = btn_s1;
	assign wr_state.motion  = motion_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			act_s1    <= !transfer_error && (slot_ext < 16'(NUM_SLOTS));
			slot_s1   <= slot_idx;
			btn_s1    <= button_byte[NB-1:0];
			motion_s1 <= {move_z, move_y, move_x};
		end
	end

	// Stage 2: load a fresh list or advance through the current one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			pos_s2   <= '0;
		end else if (s1_adv && act_s1 && (ev_cnt != '0)) begin
			valid_s2 <= 1'b1;
			pos_s2   <= '0;
		end else if (out_done) begin
			valid_s2 <= 1'b0;
			pos_s2   <= '0;
		end else if (out_acc) begin
			pos_s2 <= pos_s2 + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && act_s1 && (ev_cnt != '0)) begin
			ev_s2  <= ev_list;
			cnt_s2 <= ev_cnt;
			mx_s2  <= motion_s1[7:0];
			my_s2  <= motion_s1[15:8];
			mz_s2  <= motion_s1[23:16];
		end
	end

	assign out_valid   = valid_s2;
	assign event_kind  = ev_s2[pos_s2].kind;
	assign button_code = ev_s2[pos_s2].code;
	assign out_x       = mx_s2;
	assign out_y       = my_s2;
	assign out_z       = mz_s2;
	assign last_event  = (CNT_W'(pos_s2) + 1'b1) == cnt_s2;

	// Checks on the internal pipeline
	a_pos_in_list: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (CNT_W'(pos_s2) < cnt_s2))
		else $error("stage 2 position beyond its event list");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (cnt_s2 != '0) && (cnt_s2 <= CNT_W'(NE)))
		else $error("stage 2 holds an empty or oversized event list");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && act_s1 && (ev_cnt != '0)) |-> s2_free)
		else $error("stage 1 loads over an unfinished event list");

	a_write_source: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (valid_s1 && act_s1))
		else $error("state write without an accepted report");

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the mouse report event generator
// Drives mouse reports through the valid/ready input and predicts the press,
// hold, release and motion items of each one from a per-slot copy of the
// button and motion state. Every output item is checked field by field.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	// One output item as the block should send it
	typedef struct {
		mreg_pkg::kind_t   kind;
		logic [1:0]        code;
		logic signed [7:0] x;
		logic signed [7:0] y;
		logic signed [7:0] z;
		logic              last;
	} mouse_event_t;

	logic              clk            = 1'b0;
	logic              arst_n         = 1'b0;
	logic              in_valid       = 1'b0;
	logic              in_ready;
	logic [1:0]        device_slot    = '0;
	logic              transfer_error = 1'b0;
	logic [7:0]        button_byte    = '0;
	logic signed [7:0] move_x         = '0;
	logic signed [7:0] move_y         = '0;
	logic signed [7:0] move_z         = '0;
	logic              out_valid;
	logic              out_ready      = 1'b0;
	logic [1:0]        event_kind;
	logic [1:0]        button_code;
	logic signed [7:0] out_x;
	logic signed [7:0] out_y;
	logic signed [7:0] out_z;
	logic              last_event;

	// Predicted items still owed by the block, oldest first
	mouse_event_t pending_events[$];

	// Bench copy of the per-slot state
	logic [2:0]  slot_buttons[mreg_pkg::NUM_SLOTS_DEF];
	logic [23:0] slot_motion[mreg_pkg::NUM_SLOTS_DEF];

	int  mismatch_count = 0;
	int  reports_sent   = 0;
	int  reports_failed = 0;
	int  events_checked = 0;
	int  kind_seen[4];
	bit  full_rate      = 1'b1;

	mouse_report_event_generator DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.device_slot    (device_slot),
		.transfer_error (transfer_error),
		.button_byte    (button_byte),
		.move_x         (move_x),
		.move_y         (move_y),
		.move_z         (move_z),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.event_kind     (event_kind),
		.button_code    (button_code),
		.out_x          (out_x),
		.out_y          (out_y),
		.out_z          (out_z),
		.last_event     (last_event)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Hard stop: far beyond the slowest legal run with every stall at its longest
	initial begin
		#20_000_000;
		$display("timeout: %0d items still expected", pending_events.size());
		$display("[FAIL] regression broken");
		$finish;
	end

	// Idle length: mostly none or short, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (full_rate || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Work out the items one accepted report causes and queue them
	function automatic void predict_report_events(logic [1:0] slot, logic err,
			logic [7:0] btn_byte, logic signed [7:0] mx, logic signed [7:0] my,
			logic signed [7:0] mz);
		logic [2:0]   btn;
		logic [2:0]   old;
		logic [23:0]  motion;
		bit           emitted;
		int           n;
		mouse_event_t list[4];

		// Drop failed transfers without touching the state
		if (err)
			return;
		if (int'(slot) >= mreg_pkg::NUM_SLOTS_DEF)
			return;
		btn     = btn_byte[2:0];
		old     = slot_buttons[slot];
		motion  = {mz, my, mx};
		emitted = 1'b0;
		n       = 0;
		for (int b = 0; b < 3; b++) begin
			if (btn[b]) begin
				list[n] = '{old[b] ? mreg_pkg::KIND_HOLD : mreg_pkg::KIND_PRESS,
					2'(b + 1), mx, my, mz, 1'b0};
				n++;
				emitted = 1'b1;
			end else if (motion != '0 && motion != slot_motion[slot] && !emitted) begin
				list[n] = '{mreg_pkg::KIND_MOTION, mreg_pkg::CODE_NONE,
					mx, my, mz, 1'b0};
				n++;
				emitted = 1'b1;
			end
		end
		for (int b = 0; b < 3; b++) begin
			if (!btn[b] && old[b]) begin
				list[n] = '{mreg_pkg::KIND_RELEASE, 2'(b + 1), mx, my, mz, 1'b0};
				n++;
			end
		end
		if (n > 0)
			list[n-1].last = 1'b1;
		for (int i = 0; i < n; i++)
			pending_events.push_back(list[i]);
		slot_buttons[slot] = btn;
		slot_motion[slot]  = motion;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		mismatch_count++;
		$display("mismatch at %0t on item %0d: %s got %0d expected %0d",
			$realtime, events_checked, what, got, want);
	endtask

	// Present one report and hold it until the handshake takes it
	task automatic send_report(logic [1:0] slot, logic err, logic [7:0] btn,
			logic [7:0] mx, logic [7:0] my, logic [7:0] mz);
		@(negedge clk);
		in_valid       <= 1'b1;
		device_slot    <= slot;
		transfer_error <= err;
		button_byte    <= btn;
		move_x         <= mx;
		move_y         <= my;
		move_z         <= mz;
		do
			@(posedge clk);
		while (!in_ready);
		predict_report_events(slot, err, btn, mx, my, mz);
		reports_sent++;
		if (err)
			reports_failed++;
	endtask

	// Drop valid for a number of cycles; zero keeps the stream going
	task automatic idle_sender(int cycles);
		if (cycles > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (cycles - 1) @(negedge clk);
		end
	endtask

	task automatic wait_drained();
		while (pending_events.size() != 0)
			@(posedge clk);
	endtask

	// Random report biased toward button sequences that reach hold and release.
	// Returns 1 when the report carried a transfer error.
	task automatic send_random_report(output bit was_error);
		logic [1:0] slot;
		logic [2:0] btn;
		logic [7:0] upper;
		logic [7:0] mx, my, mz;
		int         r;

		slot      = 2'($urandom_range(0, 3));
		was_error = ($urandom_range(0, 9) == 0);
		upper     = 8'($urandom);
		r         = $urandom_range(0, 3);
		case (r)
			0: btn = 3'($urandom);
			1: btn = slot_buttons[slot];
			2: btn = slot_buttons[slot] ^ (3'b001 << $urandom_range(0, 2));
			default: btn = 3'b000;
		endcase
		r = $urandom_range(0, 9);
		if (r < 3) begin
			{mz, my, mx} = '0;
		end else if (r < 5) begin
			{mz, my, mx} = slot_motion[slot];
		end else if (r == 5) begin
			mx = $urandom_range(0, 1) ? 8'h7f : 8'h80;
			my = $urandom_range(0, 1) ? 8'h7f : 8'h80;
			mz = $urandom_range(0, 1) ? 8'h7f : 8'h00;
		end else begin
			{mz, my, mx} = 24'($urandom);
		end
		send_report(slot, was_error, {upper[7:3], btn}, mx, my, mz);
	endtask

	// Hand-picked reports at full rate: errors, empty reports, extremes,
	// every kind, suppressed motion and the four-item report
	task automatic test_directed_reports();
		full_rate = 1'b1;
		send_report(2'd0, 1'b1, 8'h07, 8'h01, 8'h01, 8'h01);  // dropped on error
		send_report(2'd0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00);  // nothing to say
		send_report(2'd0, 1'b0, 8'h00, 8'h7f, 8'h80, 8'h7f);  // motion only
		send_report(2'd0, 1'b0, 8'h00, 8'h7f, 8'h80, 8'h7f);  // same motion, silent
		send_report(2'd0, 1'b0, 8'h07, 8'h80, 8'h80, 8'h80);  // three presses
		send_report(2'd0, 1'b0, 8'h07, 8'h80, 8'h80, 8'h80);  // three holds
		send_report(2'd0, 1'b0, 8'hf8, 8'h05, 8'h00, 8'h00);  // motion, three releases
		send_report(2'd1, 1'b0, 8'h01, 8'h03, 8'h04, 8'h05);  // press suppresses motion
		send_report(2'd1, 1'b0, 8'h02, 8'h03, 8'h04, 8'h05);  // same motion: press and release, no motion
		send_report(2'd1, 1'b0, 8'h04, 8'hff, 8'hff, 8'hff);  // motion before press
		send_report(2'd2, 1'b1, 8'h05, 8'h10, 8'h20, 8'h30);  // error keeps state
		send_report(2'd2, 1'b0, 8'h05, 8'h00, 8'h00, 8'h00);
		send_report(2'd3, 1'b0, 8'hff, 8'h7f, 8'h7f, 8'h7f);
		send_report(2'd3, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00);  // releases, no motion
		send_report(2'd3, 1'b0, 8'h00, 8'h00, 8'h00, 8'h80);  // wheel only
		send_report(2'd2, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00);
		send_report(2'd1, 1'b0, 8'h06, 8'h00, 8'h00, 8'h01);  // motion, press, then hold
		idle_sender(1);
		wait_drained();
	endtask

	// Bursts that stop and wait until the block has sent everything
	task automatic test_drain_pause();
		bit err;
		full_rate = 1'b0;
		repeat (3) begin
			repeat (6)
				send_random_report(err);
			idle_sender(1);
			wait_drained();
			idle_sender($urandom_range(1, 5));
		end
	endtask

	// Long random run with stalls, plus one stretch with no idling at all
	task automatic test_random_reports(int count);
		bit err;
		int good;
		good = 0;
		while (good < count) begin
			full_rate = (good >= count / 2 && good < count / 2 + 40);
			send_random_report(err);
			if (!err)
				good++;
			idle_sender(pick_gap());
		end
		full_rate = 1'b0;
		idle_sender(1);
	endtask

	// Output pacing: ready bursts broken by stalls of random length
	initial begin : rx_pacer
		int left;
		bit rdy;
		left = 0;
		rdy  = 1'b1;
		forever begin
			@(negedge clk);
			if (left == 0) begin
				if (full_rate) begin
					rdy  = 1'b1;
					left = 1;
				end else begin
					rdy  = !rdy;
					left = rdy ? $urandom_range(1, 20) : pick_gap();
					if (left == 0) begin
						rdy  = 1'b1;
						left = $urandom_range(1, 20);
					end
				end
			end
			out_ready <= rdy;
			left--;
		end
	end

	// Check each accepted output item against the oldest prediction
	always @(posedge clk) begin : result_check
		mouse_event_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_events.size() == 0) begin
				report_mismatch("items pending", 0, 1);
			end else begin
				want = pending_events.pop_front();
				if (event_kind !== want.kind)
					report_mismatch("event_kind", event_kind, want.kind);
				if (button_code !== want.code)
					report_mismatch("button_code", button_code, want.code);
				if (out_x !== want.x)
					report_mismatch("out_x", out_x, want.x);
				if (out_y !== want.y)
					report_mismatch("out_y", out_y, want.y);
				if (out_z !== want.z)
					report_mismatch("out_z", out_z, want.z);
				if (last_event !== want.last)
					report_mismatch("last_event", last_event, want.last);
				kind_seen[want.kind]++;
			end
			events_checked++;
		end
	end

	initial begin
		for (int s = 0; s < mreg_pkg::NUM_SLOTS_DEF; s++) begin
			slot_buttons[s] = '0;
			slot_motion[s]  = '0;
		end
		for (int k = 0; k < 4; k++)
			kind_seen[k] = 0;
		// Hold reset, then release it on a falling edge
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		test_directed_reports();
		test_drain_pause();
		test_random_reports(300);
		wait_drained();
		repeat (16) @(posedge clk);
		$display("covered %0d reports (%0d dropped on transfer error), %0d items checked",
			reports_sent, reports_failed, events_checked);
		$display("items by kind: press %0d, hold %0d, release %0d, motion %0d",
			kind_seen[mreg_pkg::KIND_PRESS], kind_seen[mreg_pkg::KIND_HOLD],
			kind_seen[mreg_pkg::KIND_RELEASE], kind_seen[mreg_pkg::KIND_MOTION]);
		if (mismatch_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
